// ===== rtl/decl_pkg.sv =====
// Shared constants, codes and types of the deduplicating error code log.
package decl_pkg;

    localparam int LOG_DEPTH = 16;
    localparam int ADDR_W    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int COUNT_W   = $clog2(LOG_DEPTH + 1);

    localparam int FUNC_W        = 2;
    localparam int CODE_W        = 8;
    localparam int STATUS_W      = 3;
    localparam int ENTRY_INDEX_W = 6;
    localparam int ENTRY_COUNT_W = 7;
    localparam int OUT_DATA_W    = 24;

    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [CODE_W-1:0]   t_code;
    typedef logic [FUNC_W-1:0]   t_func;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_func FUNC_LOG   = 2'd0;
    localparam t_func FUNC_READ  = 2'd1;
    localparam t_func FUNC_CLEAR = 2'd2;

    localparam t_status STAT_STORED  = 3'd0;
    localparam t_status STAT_DUP     = 3'd1;
    localparam t_status STAT_FULL    = 3'd2;
    localparam t_status STAT_CLEARED = 3'd3;
    localparam t_status STAT_ENTRY   = 3'd4;
    localparam t_status STAT_EMPTY   = 3'd5;

endpackage

// ===== rtl/decl_store.sv =====
// Code storage: one write port and one read port with a registered read.
module decl_store (
    input  logic           i_clk,
    input  logic           i_wr_en,
    input  decl_pkg::t_addr i_wr_addr,
    input  decl_pkg::t_code i_wr_data,
    input  logic           i_rd_en,
    input  decl_pkg::t_addr i_rd_addr,
    output decl_pkg::t_code o_rd_data
);

    decl_pkg::t_code r_mem [decl_pkg::LOG_DEPTH];
    decl_pkg::t_code r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // The read data holds while no read is issued, so a stalled consumer keeps it.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/dedup_error_code_log_core.sv =====
// Top level of the deduplicating error code log.
//
// The slave stream carries one command per beat: tuser holds the operation
// (log, read all, clear) and tdata the error code to log. The master stream
// returns result beats: tuser holds the status, tdata the entry index, code
// and count, and tlast marks the final beat of a command.
// A command is taken only while the block is idle. It is then decoded;
// clear, read of an empty log, a log into a full log and a log into
// an empty log then answer from decode. A log otherwise scans the stored codes
// through the single read port of the code memory, one entry per cycle.
// A read issues one memory read per cycle and returns one beat per cycle
// from the registered read data.
// A finished beat sits in an output register; while the receiver stalls, a
// read holds its place, a scan stops at its result; nothing is lost or repeated.
// Reset empties the log at once; the memory itself needs no clearing, since
// only entries below the count are ever read.
module dedup_error_code_log_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] error_code
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [5:0] entry_index, [13:6] entry_code,
                                          // [20:14] entry_count, [23:21] zero
    output logic [2:0]  o_m_axis_tuser,   // [2:0] status
    output logic        o_m_axis_tlast
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECIDE = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_READ   = 2'd3;

    logic [1:0]          r_state, n_state;
    decl_pkg::t_count    r_count, n_count;
    decl_pkg::t_func     r_func;
    decl_pkg::t_code     r_code;
    decl_pkg::t_addr     r_issue, n_issue;
    logic                r_pend, n_pend;
    decl_pkg::t_addr     r_pend_idx, n_pend_idx;

    logic                r_out_valid, n_out_valid;
    decl_pkg::t_status   r_out_status, n_out_status;
    logic [decl_pkg::ENTRY_INDEX_W-1:0] r_out_index, n_out_index;
    decl_pkg::t_code     r_out_code, n_out_code;
    logic [decl_pkg::ENTRY_COUNT_W-1:0] r_out_count, n_out_count;
    logic                r_out_last, n_out_last;

    logic                wr_en;
    decl_pkg::t_addr     wr_addr;
    logic                rd_en;
    decl_pkg::t_code     rd_data;
    logic                out_free;
    logic                in_fire;
    logic                pend_last;
    decl_pkg::t_count    count_inc;

    decl_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_code),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_issue),
        .o_rd_data (rd_data)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_fire   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign pend_last = ((decl_pkg::COUNT_W'(r_pend_idx) + 1'b1) == r_count);
    assign count_inc = r_count + 1'b1;
    assign wr_addr   = r_count[decl_pkg::ADDR_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_issue      = r_issue;
        n_pend       = r_pend;
        n_pend_idx   = r_pend_idx;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_status = r_out_status;
        n_out_index  = r_out_index;
        n_out_code   = r_out_code;
        n_out_count  = r_out_count;
        n_out_last   = r_out_last;
        wr_en        = 1'b0;
        rd_en        = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_DECIDE;
                end
            end

            ST_DECIDE: begin
                if (out_free) begin
                    n_issue = '0;
                    n_pend  = 1'b0;
                    n_state = ST_IDLE;
                    case (r_func)
                        decl_pkg::FUNC_LOG: begin
                            if (r_count == decl_pkg::COUNT_W'(decl_pkg::LOG_DEPTH)) begin
                                n_out_valid  = 1'b1;
                                n_out_status = decl_pkg::STAT_FULL;
                                n_out_index  = '0;
                                n_out_code   = r_code;
                                n_out_count  = decl_pkg::ENTRY_COUNT_W'(r_count);
                                n_out_last   = 1'b1;
                            end else if (r_count == '0) begin
                                wr_en        = 1'b1;
                                n_count      = count_inc;
                                n_out_valid  = 1'b1;
                                n_out_status = decl_pkg::STAT_STORED;
                                n_out_index  = '0;
                                n_out_code   = r_code;
                                n_out_count  = decl_pkg::ENTRY_COUNT_W'(count_inc);
                                n_out_last   = 1'b1;
                            end else begin
                                n_state = ST_SEARCH;
                            end
                        end
                        decl_pkg::FUNC_READ: begin
                            if (r_count == '0) begin
                                n_out_valid  = 1'b1;
                                n_out_status = decl_pkg::STAT_EMPTY;
                                n_out_index  = '0;
                                n_out_code   = '0;
                                n_out_count  = '0;
                                n_out_last   = 1'b1;
                            end else begin
                                n_state = ST_READ;
                            end
                        end
                        decl_pkg::FUNC_CLEAR: begin
                            n_count      = '0;
                            n_out_valid  = 1'b1;
                            n_out_status = decl_pkg::STAT_CLEARED;
                            n_out_index  = '0;
                            n_out_code   = '0;
                            n_out_count  = '0;
                            n_out_last   = 1'b1;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SEARCH: begin
                // Compare the data of the last issued read with the code.
                if (r_pend && (rd_data == r_code)) begin
                    if (out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_status = decl_pkg::STAT_DUP;
                        n_out_index  = decl_pkg::ENTRY_INDEX_W'(r_pend_idx);
                        n_out_code   = r_code;
                        n_out_count  = decl_pkg::ENTRY_COUNT_W'(r_count);
                        n_out_last   = 1'b1;
                        n_pend       = 1'b0;
                        n_state      = ST_IDLE;
                    end
                end else if (r_pend && pend_last) begin
                    if (out_free) begin
                        wr_en        = 1'b1;
                        n_count      = count_inc;
                        n_out_valid  = 1'b1;
                        n_out_status = decl_pkg::STAT_STORED;
                        n_out_index  = decl_pkg::ENTRY_INDEX_W'(r_count);
                        n_out_code   = r_code;
                        n_out_count  = decl_pkg::ENTRY_COUNT_W'(count_inc);
                        n_out_last   = 1'b1;
                        n_pend       = 1'b0;
                        n_state      = ST_IDLE;
                    end
                end else begin
                    rd_en      = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_issue;
                    n_issue    = r_issue + 1'b1;
                end
            end

            ST_READ: begin
                if (r_pend) begin
                    if (out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_status = decl_pkg::STAT_ENTRY;
                        n_out_index  = decl_pkg::ENTRY_INDEX_W'(r_pend_idx);
                        n_out_code   = rd_data;
                        n_out_count  = decl_pkg::ENTRY_COUNT_W'(r_count);
                        n_out_last   = pend_last;
                        if (pend_last) begin
                            n_pend  = 1'b0;
                            n_state = ST_IDLE;
                        end else begin
                            rd_en      = 1'b1;
                            n_pend_idx = r_issue;
                            n_issue    = r_issue + 1'b1;
                        end
                    end
                end else begin
                    rd_en      = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_issue;
                    n_issue    = r_issue + 1'b1;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_func <= i_s_axis_tuser;
            r_code <= i_s_axis_tdata;
        end
        r_issue      <= n_issue;
        r_pend_idx   <= n_pend_idx;
        r_out_status <= n_out_status;
        r_out_index  <= n_out_index;
        r_out_code   <= n_out_code;
        r_out_count  <= n_out_count;
        r_out_last   <= n_out_last;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {3'b000, r_out_count, r_out_code, r_out_index};

endmodule

// ===== tb/code_log_checker.sv =====
// Checker for the error code log: predicts result beats from accepted commands and compares them.
module code_log_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] error_code
    input  logic [1:0]  i_s_tuser,   // [1:0] func
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // [5:0] entry_index, [13:6] entry_code,
                                     // [20:14] entry_count, [23:21] zero
    input  logic [2:0]  i_m_tuser,   // [2:0] status
    input  logic        i_m_tlast,
    output int          o_errors,
    output int          o_pending,
    output int          o_commands,
    output int          o_beats,
    output int          o_dup_hits,
    output int          o_full_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        decl_pkg::t_status                   status;
        logic [decl_pkg::ENTRY_INDEX_W-1:0]  index;
        decl_pkg::t_code                     code;
        logic [decl_pkg::ENTRY_COUNT_W-1:0]  count;
        logic                                last;
    } t_log_beat;

    // Shadow copy of the log contents.
    decl_pkg::t_code log_codes [decl_pkg::LOG_DEPTH];
    int              log_count;
    t_log_beat       expected_beats [$];

    int errors    = 0;
    int commands  = 0;
    int beats     = 0;
    int dup_hits  = 0;
    int full_hits = 0;

    task automatic note_failure(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        errors++;
    endtask

    function automatic void predict_command(input decl_pkg::t_func func,
                                            input decl_pkg::t_code code);
        t_log_beat b;
        int hit;
        int i;
        b   = '0;
        hit = -1;
        case (func)
            decl_pkg::FUNC_LOG: begin
                for (i = 0; i < log_count; i++)
                    if (hit < 0 && log_codes[i] == code)
                        hit = i;
                b.code = code;
                b.last = 1'b1;
                // A full log answers full even when the code is already stored.
                if (log_count >= decl_pkg::LOG_DEPTH) begin
                    b.status = decl_pkg::STAT_FULL;
                    full_hits++;
                end else if (hit >= 0) begin
                    b.status = decl_pkg::STAT_DUP;
                    b.index  = decl_pkg::ENTRY_INDEX_W'(hit);
                    dup_hits++;
                end else begin
                    log_codes[log_count] = code;
                    b.status = decl_pkg::STAT_STORED;
                    b.index  = decl_pkg::ENTRY_INDEX_W'(log_count);
                    log_count++;
                end
                b.count = decl_pkg::ENTRY_COUNT_W'(log_count);
                expected_beats.push_back(b);
            end
            decl_pkg::FUNC_READ: begin
                if (log_count == 0) begin
                    b.status = decl_pkg::STAT_EMPTY;
                    b.last   = 1'b1;
                    expected_beats.push_back(b);
                end else begin
                    for (i = 0; i < log_count; i++) begin
                        b.status = decl_pkg::STAT_ENTRY;
                        b.index  = decl_pkg::ENTRY_INDEX_W'(i);
                        b.code   = log_codes[i];
                        b.count  = decl_pkg::ENTRY_COUNT_W'(log_count);
                        b.last   = (i == log_count - 1);
                        expected_beats.push_back(b);
                    end
                end
            end
            decl_pkg::FUNC_CLEAR: begin
                log_count = 0;
                b.status  = decl_pkg::STAT_CLEARED;
                b.last    = 1'b1;
                expected_beats.push_back(b);
            end
            default: ;  // the unused operation is dropped without an answer
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_log_beat want;
        if (!i_rst_n) begin
            log_count = 0;
            expected_beats.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_beats.size() == 0) begin
                    note_failure($sformatf("beat %0d arrived with nothing expected (status %0d)",
                                           beats, i_m_tuser));
                end else begin
                    want = expected_beats.pop_front();
                    if (i_m_tuser != want.status)
                        note_failure($sformatf("beat %0d status %0d, expected %0d",
                                               beats, i_m_tuser, want.status));
                    if (i_m_tdata[5:0] != want.index)
                        note_failure($sformatf("beat %0d entry_index %0d, expected %0d",
                                               beats, i_m_tdata[5:0], want.index));
                    if (i_m_tdata[13:6] != want.code)
                        note_failure($sformatf("beat %0d entry_code 0x%02h, expected 0x%02h",
                                               beats, i_m_tdata[13:6], want.code));
                    if (i_m_tdata[20:14] != want.count)
                        note_failure($sformatf("beat %0d entry_count %0d, expected %0d",
                                               beats, i_m_tdata[20:14], want.count));
                    if (i_m_tlast != want.last)
                        note_failure($sformatf("beat %0d tlast %0b, expected %0b",
                                               beats, i_m_tlast, want.last));
                    if (i_m_tdata[23:21] != 3'b000)
                        note_failure($sformatf("beat %0d padding bits 0x%0h, expected zero",
                                               beats, i_m_tdata[23:21]));
                end
                beats++;
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_command(decl_pkg::t_func'(i_s_tuser), decl_pkg::t_code'(i_s_tdata));
                commands++;
            end
        end
        // Exported through registers so readers never race the update above.
        o_errors    <= errors;
        o_pending   <= expected_beats.size();
        o_commands  <= commands;
        o_beats     <= beats;
        o_dup_hits  <= dup_hits;
        o_full_hits <= full_hits;
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the error code log: clock, reset, command stimulus, receiver stalls, verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam decl_pkg::t_func FUNC_UNUSED  = 2'd3;
    localparam int              RANDOM_ITEMS = 400;
    localparam int              TAIL_CYCLES  = 40;
    localparam int              LIMIT_CYCLES = 400000;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic [7:0]  s_tdata    = '0;
    logic [1:0]  s_tuser    = '0;
    logic        m_tready   = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    int errors, pending, commands, beats, dup_hits, full_hits;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycles        = 0;

    dedup_error_code_log_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    code_log_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_m_tlast   (m_tlast),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_commands  (commands),
        .o_beats     (beats),
        .o_dup_hits  (dup_hits),
        .o_full_hits (full_hits)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d beats outstanding", cycles, pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offers one command beat, with random idle cycles ahead of it, and returns
    // at the edge where it is taken; tvalid is left high for the caller.
    task automatic send_cmd(input decl_pkg::t_func func, input decl_pkg::t_code code);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= code;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
    endtask

    // Holds the command stream off until every predicted beat has come back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // Half the codes come from a small set so that duplicates are common.
    function automatic decl_pkg::t_code pick_code();
        if ($urandom_range(1, 0) == 0)
            return decl_pkg::t_code'($urandom_range(15, 0) * 17);
        return decl_pkg::t_code'($urandom_range(255, 0));
    endfunction

    function automatic decl_pkg::t_func pick_func();
        int r;
        r = $urandom_range(99, 0);
        if (r < 78)
            return decl_pkg::FUNC_LOG;
        if (r < 93)
            return decl_pkg::FUNC_READ;
        if (r < 97)
            return decl_pkg::FUNC_CLEAR;
        return FUNC_UNUSED;
    endfunction

    initial begin
        int              phase;
        int              sent;
        int              i;
        decl_pkg::t_func func;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 9;
        recv_idle_pct = 63;

        // Directed: empty read, extreme codes, duplicates, the unused operation,
        // clear, then fill the log to the top and hit it with a stored code.
        send_cmd(decl_pkg::FUNC_READ, 8'h00);
        send_cmd(decl_pkg::FUNC_LOG, 8'h00);
        send_cmd(decl_pkg::FUNC_LOG, 8'hFF);
        send_cmd(decl_pkg::FUNC_LOG, 8'hFF);
        send_cmd(decl_pkg::FUNC_LOG, 8'h00);
        send_cmd(FUNC_UNUSED, 8'hA5);
        send_cmd(decl_pkg::FUNC_READ, 8'h5A);
        send_cmd(decl_pkg::FUNC_CLEAR, 8'hFF);
        send_cmd(decl_pkg::FUNC_READ, 8'h00);
        for (i = 0; i < decl_pkg::LOG_DEPTH; i++)
            send_cmd(decl_pkg::FUNC_LOG, decl_pkg::t_code'(i * 16 + 15 - i));
        send_cmd(decl_pkg::FUNC_LOG, 8'hF0);
        send_cmd(decl_pkg::FUNC_READ, 8'h00);
        wait_for_results();

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 9;
                    recv_idle_pct = 63;
                end
                1: begin
                    send_idle_pct = 63;
                    recv_idle_pct = 9;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < RANDOM_ITEMS / 3) begin
                func = pick_func();
                send_cmd(func, pick_code());
                if (func != FUNC_UNUSED)
                    sent++;
            end
            if (phase == 0)
                wait_for_results();
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d commands and %0d result beats,", commands, beats);
        $display("with %0d duplicate and %0d full answers.", dup_hits, full_hits);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
